// File: hdl/cumulative_ack_tracker_top_macros.svh
// Assertion macros for the cumulative ack tracker.
`ifndef CUMULATIVE_ACK_TRACKER_TOP_MACROS_SVH
`define CUMULATIVE_ACK_TRACKER_TOP_MACROS_SVH
`ifndef SYNTH
`define CAT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CAT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CAT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define CAT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: hdl/cat_pkg.sv
// Types and constants shared by the cumulative ack tracker modules.
package cat_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    REG_ACK_INTERVAL = 1'b0,
    REG_PEER_ID      = 1'b1
  } reg_idx_t;

  typedef enum logic {
    KIND_OBSERVE = 1'b0,
    KIND_UPDATE  = 1'b1
  } kind_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [1:0] {
    SEL_OBS  = 2'd0,
    SEL_ADV  = 2'd1,
    SEL_TICK = 2'd2
  } alu_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_OBS  = 2'd1,
    ST_ADV  = 2'd2,
    ST_TICK = 2'd3
  } state_t;

  typedef struct packed {
    logic     in_ready;
    alu_sel_t alu_sel;
    logic     obs_load;
    logic     adv_step;
    logic     tick_load;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic kind;
    logic win_lsb;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/cat_alu.sv
// Shared 32-bit adder/subtractor with carry (no-borrow) out.
module cat_alu (
  input  cat_pkg::alu_op_t         op,
  input  logic [cat_pkg::DATA_W-1:0] a,
  input  logic [cat_pkg::DATA_W-1:0] b,
  output logic [cat_pkg::DATA_W-1:0] result,
  output logic                     carry
);
  import cat_pkg::*;

  logic [DATA_W-1:0] b_eff;
  logic [DATA_W:0]   sum;

  always_comb begin
    case (op)
      ALU_ADD: b_eff = b;
      ALU_SUB: b_eff = ~b;
      default: b_eff = b;
    endcase
  end

  assign sum    = {1'b0, a} + {1'b0, b_eff} + {{DATA_W{1'b0}}, (op == ALU_SUB)};
  assign result = sum[DATA_W-1:0];
  assign carry  = sum[DATA_W];

endmodule

// File: hdl/cat_ctrl.sv
// Sequencer for observe and update items.
module cat_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  cat_pkg::stat_t stat,
  output cat_pkg::ctrl_t ctrl
);
  import cat_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (stat.in_valid) begin
          state_next = (stat.kind == KIND_UPDATE) ? ST_ADV : ST_OBS;
        end
      end
      ST_OBS: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_ADV: begin
        if (!stat.win_lsb) begin
          state_next = ST_TICK;
        end
      end
      ST_TICK: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.alu_sel = SEL_OBS;
    case (state)
      ST_IDLE: ctrl.in_ready = 1'b1;
      ST_OBS: begin
        ctrl.alu_sel  = SEL_OBS;
        ctrl.obs_load = stat.out_free;
      end
      ST_ADV: begin
        ctrl.alu_sel  = SEL_ADV;
        ctrl.adv_step = stat.win_lsb;
      end
      ST_TICK: begin
        ctrl.alu_sel   = SEL_TICK;
        ctrl.tick_load = stat.out_free;
      end
      default: ctrl.in_ready = 1'b0;
    endcase
  end

endmodule

// File: hdl/cumulative_ack_tracker_top.sv
// Top level of the cumulative ack tracker: state, window and result register.
//
//  channel | signals                                   | accepted when
//  --------+-------------------------------------------+-----------------------
//  config  | cfg_we cfg_index cfg_data                 | cfg_we high
//  input   | in_valid in_ready kind serial now_ticks   | in_valid & in_ready
//          | peer_positive                             |
//  output  | out_valid out_ready ack_send ack_recipient| out_valid & out_ready
//          | ack_max out_of_window                     |
//
// Observe item: capture, then one pass through the shared adder.
// Update item: capture, k window steps, tick check; k = run of received serials
// at the window base (0..WINDOW); the window slides one place per cycle through
// the shared adder. Reset clears state, settings and out_valid; no clearing pass.
// A finished result waits in the output register; the last step of the
// following item holds until that result is taken.
`include "cumulative_ack_tracker_top_macros.svh"

module cumulative_ack_tracker_top #(
  parameter int unsigned WINDOW = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  cat_pkg::reg_idx_t          cfg_index,
  input  logic [cat_pkg::DATA_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       kind,
  input  logic [cat_pkg::DATA_W-1:0] serial,
  input  logic [cat_pkg::DATA_W-1:0] now_ticks,
  input  logic                       peer_positive,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       ack_send,
  output logic [cat_pkg::DATA_W-1:0] ack_recipient,
  output logic [cat_pkg::DATA_W-1:0] ack_max,
  output logic                       out_of_window
);
  import cat_pkg::*;

  localparam int unsigned IDX_W = $clog2(WINDOW);
  localparam logic [WINDOW-1:0] WIN_ONE = {{(WINDOW-1){1'b0}}, 1'b1};
  localparam logic [DATA_W-1:0] WIN_SIZE = DATA_W'(WINDOW);

  logic [DATA_W-1:0] ack_interval;
  logic [DATA_W-1:0] peer_id;
  logic [DATA_W-1:0] next_expected;
  logic [WINDOW-1:0] seen_window;
  logic [DATA_W-1:0] last_ack_tick;

  logic              kind_r;
  logic [DATA_W-1:0] serial_r;
  logic [DATA_W-1:0] now_r;
  logic              positive_r;

  ctrl_t             ctrl;
  stat_t             stat;
  alu_op_t           alu_op;
  logic [DATA_W-1:0] alu_a;
  logic [DATA_W-1:0] alu_b;
  logic [DATA_W-1:0] alu_res;
  logic              alu_carry;
  logic              in_win;
  logic              fire;

  assign in_ready = ctrl.in_ready;

  assign stat.in_valid = in_valid;
  assign stat.kind     = kind;
  assign stat.win_lsb  = seen_window[0];
  assign stat.out_free = !out_valid || out_ready;

  cat_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  always_comb begin
    case (ctrl.alu_sel)
      SEL_OBS: begin
        alu_op = ALU_SUB;
        alu_a  = serial_r;
        alu_b  = next_expected;
      end
      SEL_ADV: begin
        alu_op = ALU_ADD;
        alu_a  = next_expected;
        alu_b  = {{(DATA_W-1){1'b0}}, 1'b1};
      end
      SEL_TICK: begin
        alu_op = ALU_SUB;
        alu_a  = now_r;
        alu_b  = last_ack_tick;
      end
      default: begin
        alu_op = ALU_SUB;
        alu_a  = serial_r;
        alu_b  = next_expected;
      end
    endcase
  end

  cat_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .result (alu_res),
    .carry  (alu_carry)
  );

  assign in_win = alu_res < WIN_SIZE;
  assign fire   = (alu_res >= ack_interval) && positive_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_interval <= DATA_W'(2);
      peer_id      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACK_INTERVAL: ack_interval <= cfg_data;
        REG_PEER_ID:      peer_id      <= cfg_data;
        default:          ack_interval <= ack_interval;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ctrl.in_ready) begin
      kind_r     <= kind;
      serial_r   <= serial;
      now_r      <= now_ticks;
      positive_r <= peer_positive;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_expected <= '0;
      seen_window   <= '0;
      last_ack_tick <= '0;
    end else begin
      if (ctrl.obs_load && in_win) begin
        seen_window <= seen_window | (WIN_ONE << alu_res[IDX_W-1:0]);
      end
      if (ctrl.adv_step) begin
        seen_window   <= {1'b0, seen_window[WINDOW-1:1]};
        next_expected <= alu_res;
      end
      if (ctrl.tick_load && fire) begin
        last_ack_tick <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.obs_load || ctrl.tick_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.obs_load) begin
      ack_send      <= 1'b0;
      ack_recipient <= '0;
      ack_max       <= '0;
      out_of_window <= !in_win && alu_carry;
    end else if (ctrl.tick_load) begin
      ack_send      <= fire;
      ack_recipient <= fire ? peer_id : '0;
      ack_max       <= fire ? next_expected : '0;
      out_of_window <= 1'b0;
    end
  end

  `CAT_ASSERT_IMPL(a_load_free, clk, rst, (ctrl.obs_load || ctrl.tick_load), (!out_valid || out_ready), "result overwritten before taken")
  `CAT_ASSERT_NEXT(a_adv_inc, clk, rst, ctrl.adv_step, (next_expected == $past(next_expected) + DATA_W'(1)), "next expected did not step by one")
  `CAT_ASSERT_NEXT(a_tick_last, clk, rst, (ctrl.tick_load && fire), (last_ack_tick == $past(now_r)), "last ack tick not recorded")
  `CAT_ASSERT_IMPL(a_kind_seq, clk, rst, ctrl.adv_step, (kind_r == KIND_UPDATE), "window advanced on observe item")
  `CAT_ASSERT_IMPL(a_out_excl, clk, rst, out_valid, !(ack_send && out_of_window), "ack and drop flag both set")

endmodule

// File: sim/tb_cumulative_ack_tracker_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for cumulative_ack_tracker_top: directed table, then random phases.
module tb_cumulative_ack_tracker_top;
  import cat_pkg::*;

  localparam int unsigned WIN = 64;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned CYCLE_LIMIT = 900000;
  localparam int unsigned N_DIR = 24;

  typedef struct packed {
    logic        snd;
    logic [31:0] rcpt;
    logic [31:0] upto;
    logic        oow;
  } ack_res_t;

  typedef struct packed {
    kind_t       k;
    logic [31:0] s;
    logic [31:0] n;
    logic        p;
    logic        typed;
    ack_res_t    r;
  } dir_row_t;

  // rows under the reset settings: interval 2, peer 0
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{KIND_UPDATE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_UPDATE,  32'h0000_0000, 32'h0000_0001, 1'b1, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_UPDATE,  32'h0000_0000, 32'h0000_0002, 1'b0, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_UPDATE,  32'h0000_0000, 32'h0000_0002, 1'b1, 1'b1, '{1'b1, 32'h0, 32'h0, 1'b0}},
    '{KIND_OBSERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b1}},
    '{KIND_OBSERVE, 32'd64,        32'h0000_0000, 1'b0, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b1}},
    '{KIND_OBSERVE, 32'd63,        32'h0000_0000, 1'b0, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_OBSERVE, 32'd0,         32'h0000_0000, 1'b0, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_OBSERVE, 32'd0,         32'h0000_0000, 1'b0, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_OBSERVE, 32'd1,         32'h0000_0000, 1'b0, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_UPDATE,  32'h0000_0000, 32'h0000_0004, 1'b1, 1'b1, '{1'b1, 32'h0, 32'd2, 1'b0}},
    '{KIND_OBSERVE, 32'd1,         32'h0000_0000, 1'b0, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_OBSERVE, 32'd0,         32'h0000_0000, 1'b0, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_OBSERVE, 32'd65,        32'h0000_0000, 1'b0, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_OBSERVE, 32'd66,        32'h0000_0000, 1'b0, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b1}},
    '{KIND_UPDATE,  32'h0000_0000, 32'h0000_0003, 1'b1, 1'b1, '{1'b1, 32'h0, 32'd2, 1'b0}},
    '{KIND_UPDATE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b1, 32'h0, 32'd2, 1'b0}},
    '{KIND_UPDATE,  32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_UPDATE,  32'h0000_0000, 32'h0000_0001, 1'b1, 1'b1, '{1'b1, 32'h0, 32'd2, 1'b0}},
    '{KIND_OBSERVE, 32'd3,         32'h0000_0000, 1'b0, 1'b0, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_OBSERVE, 32'd2,         32'h0000_0000, 1'b0, 1'b0, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_OBSERVE, 32'd4,         32'h0000_0000, 1'b0, 1'b0, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_UPDATE,  32'h0000_0000, 32'h0000_0001, 1'b1, 1'b0, '{1'b0, 32'h0, 32'h0, 1'b0}},
    '{KIND_UPDATE,  32'h0000_0000, 32'h0000_0040, 1'b1, 1'b0, '{1'b0, 32'h0, 32'h0, 1'b0}}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  reg_idx_t          cfg_index = REG_ACK_INTERVAL;
  logic [DATA_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              kind = KIND_OBSERVE;
  logic [DATA_W-1:0] serial = '0;
  logic [DATA_W-1:0] now_ticks = '0;
  logic              peer_positive = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              ack_send;
  logic [DATA_W-1:0] ack_recipient;
  logic [DATA_W-1:0] ack_max;
  logic              out_of_window;

  // predictor state and settings
  logic [31:0]    exp_next = '0;
  logic [WIN-1:0] seen_bits = '0;
  logic [31:0]    last_tick = '0;
  logic [31:0]    cfg_interval = 32'd2;
  logic [31:0]    cfg_peer = '0;

  ack_res_t pending_results[$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned acks_seen = 0;
  int unsigned drops_seen = 0;
  int unsigned observes_sent = 0;
  int unsigned updates_sent = 0;
  int unsigned advance_peak = 0;
  int unsigned cycle_count = 0;
  logic [31:0] tick_clock = '0;
  bit calm = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_left = 0;

  cumulative_ack_tracker_top #(.WINDOW(WIN)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .serial(serial),
    .now_ticks(now_ticks), .peer_positive(peer_positive),
    .out_valid(out_valid), .out_ready(out_ready), .ack_send(ack_send),
    .ack_recipient(ack_recipient), .ack_max(ack_max), .out_of_window(out_of_window)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
      $display("cumulative_ack_tracker_top regression: fail");
      $finish;
    end
  end

  function automatic ack_res_t predict_tracker(input kind_t k, input logic [31:0] s,
                                               input logic [31:0] n, input logic p);
    ack_res_t r;
    logic [31:0] off;
    int unsigned run;
    r = '0;
    run = 0;
    if (k == KIND_OBSERVE) begin
      off = s - exp_next;
      if (off < WIN) begin
        seen_bits[off] = 1'b1;
      end else if (s >= exp_next) begin
        r.oow = 1'b1;
      end
    end else begin
      while (seen_bits[0]) begin
        seen_bits = seen_bits >> 1;
        exp_next = exp_next + 1;
        run++;
      end
      if (run > advance_peak) advance_peak = run;
      if ((n - last_tick) >= cfg_interval && p) begin
        r.snd = 1'b1;
        r.rcpt = cfg_peer;
        r.upto = exp_next;
        last_tick = n;
      end
    end
    return r;
  endfunction

  // called and left at a falling edge; valid stays high for a back-to-back item
  task automatic push_item(input kind_t k, input logic [31:0] s, input logic [31:0] n,
                           input logic p, input logic typed, input ack_res_t fixed);
    ack_res_t r;
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 99) < 32) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind = k;
    serial = s;
    now_ticks = n;
    peer_positive = p;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    r = predict_tracker(k, s, n, p);
    pending_results.push_back(typed ? fixed : r);
    if (k == KIND_OBSERVE) observes_sent++;
    else updates_sent++;
    @(negedge clk);
  endtask

  task automatic send_observe(input logic [31:0] s);
    push_item(KIND_OBSERVE, s, $urandom, $urandom_range(0, 1), 1'b0, '0);
  endtask

  // tick choices lean on the interval boundary as seen from the last ack
  task automatic send_update();
    logic [31:0] n;
    int unsigned c;
    c = $urandom_range(0, 99);
    tick_clock = tick_clock + $urandom_range(0, 3);
    if (c < 55) n = tick_clock;
    else if (c < 70) n = last_tick + cfg_interval;
    else if (c < 82) n = last_tick + cfg_interval - 1;
    else begin
      n = $urandom;
      tick_clock = n;
    end
    push_item(KIND_UPDATE, $urandom, n, $urandom_range(0, 9) != 0, 1'b0, '0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == REG_ACK_INTERVAL) cfg_interval = val;
    else cfg_peer = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    ack_res_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (ack_send) acks_seen++;
      if (out_of_window) drops_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %b %h %h %b", $time,
                 ack_send, ack_recipient, ack_max, out_of_window);
      end else begin
        want = pending_results.pop_front();
        cmp_field("ack_send", 32'(want.snd), 32'(ack_send));
        cmp_field("ack_recipient", want.rcpt, ack_recipient);
        cmp_field("ack_max", want.upto, ack_max);
        cmp_field("out_of_window", 32'(want.oow), 32'(out_of_window));
      end
    end
  end

  // receiver: random stalls, one long hold-off so the input side backs up
  always @(negedge clk) begin
    if (!hold_done && results_seen >= 400) begin
      hold_done = 1'b1;
      hold_left = 250;
    end
    if (hold_left != 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (calm) begin
      out_ready = 1'b1;
    end else begin
      out_ready = ($urandom_range(0, 99) >= 32);
    end
  end

  initial begin
    int unsigned offs [WIN];
    int unsigned run_len, j, tmp, c, phase_start;
    logic [31:0] lim;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      push_item(DIR_ROWS[i].k, DIR_ROWS[i].s, DIR_ROWS[i].n, DIR_ROWS[i].p,
                DIR_ROWS[i].typed, DIR_ROWS[i].r);
    end

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: begin write_reg(REG_ACK_INTERVAL, 32'h0);         write_reg(REG_PEER_ID, '1); end
        1: begin write_reg(REG_ACK_INTERVAL, '1);            write_reg(REG_PEER_ID, '0); end
        2: begin write_reg(REG_ACK_INTERVAL, $urandom_range(1, 20));
                 write_reg(REG_PEER_ID, $urandom); end
        3: begin write_reg(REG_ACK_INTERVAL, 32'd1);         write_reg(REG_PEER_ID, $urandom); end
        4: begin write_reg(REG_ACK_INTERVAL, $urandom);      write_reg(REG_PEER_ID, $urandom); end
        default: begin
          write_reg(REG_ACK_INTERVAL, 32'd2);
          write_reg(REG_PEER_ID, 32'hA5A5_5A5A);
        end
      endcase
      calm = (ph == 2);
      phase_start = observes_sent + updates_sent;
      while (observes_sent + updates_sent - phase_start < PHASE_ITEMS) begin
        c = $urandom_range(0, 99);
        if (c < 40) begin
          // contiguous run at the window base in shuffled order, then an update
          run_len = ($urandom_range(0, 3) == 0) ? WIN : $urandom_range(1, 16);
          for (int i = 0; i < run_len; i++) offs[i] = i;
          for (int i = run_len - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = offs[i];
            offs[i] = offs[j];
            offs[j] = tmp;
          end
          for (int i = 0; i < run_len; i++) begin
            if ($urandom_range(0, 9) == 0) send_observe($urandom);
            else if ($urandom_range(0, 9) == 0) send_observe(exp_next + offs[0]);
            send_observe(exp_next + offs[i]);
          end
          send_update();
        end else begin
          c = $urandom_range(0, 99);
          if (c < 45) begin
            send_observe(exp_next + $urandom_range(0, WIN + 8));
          end else if (c < 55) begin
            if (exp_next != 0) begin
              lim = (exp_next - 1 < 200) ? exp_next - 1 : 200;
              send_observe(exp_next - 1 - $urandom_range(0, lim));
            end else begin
              send_observe($urandom);
            end
          end else if (c < 65) begin
            send_observe($urandom);
          end else begin
            send_update();
          end
        end
      end
    end
    calm = 1'b0;
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("run covered %0d observe and %0d update items, %0d results checked",
             observes_sent, updates_sent, results_seen);
    $display("acks %0d, window drops %0d, longest single advance %0d serials",
             acks_seen, drops_seen, advance_peak);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("cumulative_ack_tracker_top regression: pass");
    end else begin
      $display("cumulative_ack_tracker_top regression: fail");
    end
    $finish;
  end

endmodule
